>>> hw/rtl/tea_variant_block_cipher_assert.svh
// Assertion macros for the TEA variant block cipher.
`ifndef TEA_VARIANT_BLOCK_CIPHER_ASSERT_SVH
`define TEA_VARIANT_BLOCK_CIPHER_ASSERT_SVH

// Checked at every rising clock edge outside reset.
`define TVBC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every rising clock edge, reset included.
`define TVBC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> hw/rtl/tvbc_pkg.sv
// Types, constants and the round function of the TEA variant block cipher.
package tvbc_pkg;

  localparam logic [31:0] Delta = 32'h9E3779B9;

  localparam logic [31:0] KeyReset0 = 32'h12447469;
  localparam logic [31:0] KeyReset1 = 32'h87873739;
  localparam logic [31:0] KeyReset2 = 32'h908ACD69;
  localparam logic [31:0] KeyReset3 = 32'hFC892782;

  typedef enum logic [1:0] {
    CfgKeyWord0 = 2'd0,
    CfgKeyWord1 = 2'd1,
    CfgKeyWord2 = 2'd2,
    CfgKeyWord3 = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic        op;
    logic [31:0] y;
    logic [31:0] z;
  } stage_t;

  function automatic logic [31:0] mix(input logic [31:0] x, input logic [31:0] s,
                                      input logic [31:0] kw);
    return ((x << 4) ^ (x >> 5)) + (x ^ s) + kw;
  endfunction

endpackage

>>> hw/rtl/tea_variant_block_cipher.sv
// Top level of the TEA variant block cipher: key registers and round pipeline.
//
// One input transfer carries the operation bit (0 encipher, 1 decipher) and the
// two 32-bit halves of a block; one output transfer returns the resulting
// halves. Each channel moves a transfer at a rising edge with valid high and
// stall low.
// The pipeline holds one half round per stage, 2*ROUNDS stages in all, and
// while the output is not stalled it takes a new block in every cycle. The
// depth of one half round (a shift, xor and three-input add followed by one
// add or subtract) sets the clock. Blocks stay in order, and bubbles travel
// through the pipeline with them. When the output is valid and stalled, the
// whole pipeline holds and the input stall follows the output stall; nothing
// is lost or repeated. The user must write the four key words through the
// configuration port only while the pipeline is empty; the block does not
// enforce this. A write to index i sets key word i. Reset empties the
// pipeline and loads the default key.
`include "tea_variant_block_cipher_assert.svh"

module tea_variant_block_cipher #(
  parameter int unsigned ROUNDS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [31:0] block_first_i,
  input  logic [31:0] block_second_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] out_first_o,
  output logic [31:0] out_second_o
);

  localparam int unsigned NumStages = 2 * ROUNDS;

  logic [31:0]       key_q [4];
  logic [NumStages-1:0] vld_q;
  tvbc_pkg::stage_t  pipe_q [NumStages];
  tvbc_pkg::stage_t  st_in  [NumStages];
  tvbc_pkg::stage_t  st_out [NumStages];
  logic              hold;

  assign hold = vld_q[NumStages-1] & out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q[0] <= tvbc_pkg::KeyReset0;
      key_q[1] <= tvbc_pkg::KeyReset1;
      key_q[2] <= tvbc_pkg::KeyReset2;
      key_q[3] <= tvbc_pkg::KeyReset3;
    end else if (cfg_we_i) begin
      case (tvbc_pkg::cfg_idx_e'(cfg_index_i))
        tvbc_pkg::CfgKeyWord0: key_q[0] <= cfg_wdata_i;
        tvbc_pkg::CfgKeyWord1: key_q[1] <= cfg_wdata_i;
        tvbc_pkg::CfgKeyWord2: key_q[2] <= cfg_wdata_i;
        tvbc_pkg::CfgKeyWord3: key_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  for (genvar h = 0; h < NumStages; h++) begin : g_stage
    localparam int unsigned Rnd = h / 2;
    localparam int unsigned Phase = h % 2;
    localparam logic [31:0] SumEnc = 32'(64'(tvbc_pkg::Delta) * 64'(Rnd + Phase));
    localparam logic [31:0] SumDec = 32'(64'(tvbc_pkg::Delta) * 64'(ROUNDS - Rnd - Phase));
    localparam logic [1:0] KeyEnc = (Phase == 0) ? SumEnc[1:0] : SumEnc[12:11];
    localparam logic [1:0] KeyDec = (Phase == 0) ? SumDec[12:11] : SumDec[1:0];

    if (h == 0) begin : g_first
      assign st_in[h] = '{op: operation_i, y: block_first_i, z: block_second_i};
    end else begin : g_next
      assign st_in[h] = pipe_q[h-1];
    end

    always_comb begin
      st_out[h] = st_in[h];
      if (!st_in[h].op) begin
        if (Phase == 0) begin
          st_out[h].y = st_in[h].y + tvbc_pkg::mix(st_in[h].z, SumEnc, key_q[KeyEnc]);
        end else begin
          st_out[h].z = st_in[h].z + tvbc_pkg::mix(st_in[h].y, SumEnc, key_q[KeyEnc]);
        end
      end else begin
        if (Phase == 0) begin
          st_out[h].z = st_in[h].z - tvbc_pkg::mix(st_in[h].y, SumDec, key_q[KeyDec]);
        end else begin
          st_out[h].y = st_in[h].y - tvbc_pkg::mix(st_in[h].z, SumDec, key_q[KeyDec]);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (!hold) begin
      vld_q <= {vld_q[NumStages-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (!hold) begin
      for (int i = 0; i < NumStages; i++) begin
        pipe_q[i] <= st_out[i];
      end
    end
  end

  assign in_stall_o   = hold;
  assign out_valid_o  = vld_q[NumStages-1];
  assign out_first_o  = pipe_q[NumStages-1].y;
  assign out_second_o = pipe_q[NumStages-1].z;

  `TVBC_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> vld_q == '0, "pipeline not empty in reset")
  `TVBC_ASSERT(a_hold_keeps, hold |=> vld_q == $past(vld_q), "valid bits moved during a hold")
  `TVBC_ASSERT(a_enter, !hold |=> vld_q[0] == $past(in_valid_i), "input transfer not captured")
  `TVBC_ASSERT(a_key_write,
               cfg_we_i && cfg_index_i == tvbc_pkg::CfgKeyWord0 |=> key_q[0] == $past(cfg_wdata_i),
               "key word 0 write lost")

endmodule

>>> bench/tea_variant_block_cipher_tb.sv
// Testbench for the TEA variant block cipher: directed and random traffic checked against a cycle-free model.
module tea_variant_block_cipher_tb;

  localparam int unsigned ROUNDS = 32;
  localparam logic [31:0] GOLDEN_RATIO = 32'h9E3779B9;

  class cipher_scoreboard;
    logic [31:0] key_word [4];
    logic [63:0] block_q [$];
    int errors;

    function new();
      key_word[0] = 32'h12447469;
      key_word[1] = 32'h87873739;
      key_word[2] = 32'h908ACD69;
      key_word[3] = 32'hFC892782;
      errors = 0;
    endfunction

    function void set_key(tvbc_pkg::cfg_idx_e idx, logic [31:0] value);
      key_word[idx] = value;
    endfunction

    function int pending();
      return block_q.size();
    endfunction

    function logic [31:0] feistel(logic [31:0] x, logic [31:0] sum, logic [31:0] kw);
      logic [31:0] shifted;
      shifted = {x[27:0], 4'b0} ^ {5'b0, x[31:5]};
      return shifted + (x ^ sum) + kw;
    endfunction

    function logic [63:0] cipher(bit decipher, logic [31:0] y, logic [31:0] z);
      logic [31:0] sum;
      if (!decipher) begin
        sum = '0;
        for (int r = 0; r < ROUNDS; r++) begin
          y = y + feistel(z, sum, key_word[sum[1:0]]);
          sum = sum + GOLDEN_RATIO;
          z = z + feistel(y, sum, key_word[sum[12:11]]);
        end
      end else begin
        sum = GOLDEN_RATIO * ROUNDS;
        for (int r = 0; r < ROUNDS; r++) begin
          z = z - feistel(y, sum, key_word[sum[12:11]]);
          sum = sum - GOLDEN_RATIO;
          y = y - feistel(z, sum, key_word[sum[1:0]]);
        end
      end
      return {y, z};
    endfunction

    function void note_input(bit decipher, logic [31:0] y, logic [31:0] z);
      block_q.push_back(cipher(decipher, y, z));
    endfunction

    task report(string msg);
      $display("%0t: mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [31:0] y, logic [31:0] z);
      logic [63:0] want;
      if (block_q.size() == 0) begin
        report($sformatf("unexpected result %h %h", y, z));
      end else begin
        want = block_q.pop_front();
        if (y !== want[63:32])
          report($sformatf("out_first %h, expected %h", y, want[63:32]));
        if (z !== want[31:0])
          report($sformatf("out_second %h, expected %h", z, want[31:0]));
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        operation_i = 1'b0;
  logic [31:0] block_first_i = '0;
  logic [31:0] block_second_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] out_first_o;
  logic [31:0] out_second_o;

  cipher_scoreboard sb = new();
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  bit hold_req = 1'b0;

  tea_variant_block_cipher #(
    .ROUNDS(ROUNDS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .block_first_i (block_first_i),
    .block_second_i(block_second_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_first_o   (out_first_o),
    .out_second_o  (out_second_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      sb.note_input(operation_i, block_first_i, block_second_i);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(out_first_o, out_second_o);
  end

  // The receiver stalls in runs; a hold request from the sender makes it back off for long.
  initial begin
    int pick;
    int run;
    @(posedge clk_i iff rst_ni);
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
        @(posedge clk_i);
      end else begin
        pick = $urandom_range(0, 99);
        if (rx_quiet || pick < 60) begin
          out_stall_i <= 1'b0;
          run = $urandom_range(1, 8);
        end else if (pick < 92) begin
          out_stall_i <= 1'b1;
          run = $urandom_range(1, 3);
        end else begin
          out_stall_i <= 1'b1;
          run = $urandom_range(10, 40);
        end
        repeat (run) @(posedge clk_i);
      end
    end
  end

  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (tx_quiet || pick < 70) return 0;
    if (pick < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 32'h1 << $urandom_range(0, 31);
      3: return ~(32'h1 << $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  task automatic send_block(bit decipher, logic [31:0] y, logic [31:0] z);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= decipher;
    block_first_i <= y;
    block_second_i <= z;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_keys(logic [3:0] mask, logic [31:0] w0, logic [31:0] w1,
                            logic [31:0] w2, logic [31:0] w3);
    logic [31:0] words [4];
    words = '{w0, w1, w2, w3};
    for (int i = 0; i < 4; i++) begin
      if (mask[i]) begin
        cfg_we_i <= 1'b1;
        cfg_index_i <= tvbc_pkg::cfg_idx_e'(i);
        cfg_wdata_i <= words[i];
        @(posedge clk_i);
        sb.set_key(tvbc_pkg::cfg_idx_e'(i), words[i]);
      end
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(int count);
    logic [63:0] plain;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 5) == 0) begin
        // Decipher a block whose plaintext is built from picked words and so is known.
        plain = {pick_word(), pick_word()};
        plain = sb.cipher(1'b0, plain[63:32], plain[31:0]);
        send_block(1'b1, plain[63:32], plain[31:0]);
      end else begin
        send_block(1'($urandom_range(0, 1)), pick_word(), pick_word());
      end
    end
  endtask

  initial begin
    #200_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    logic [63:0] ct;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_quiet = 1'b1;
    for (int op = 0; op < 2; op++) begin
      send_block(1'(op), 32'h0, 32'h0);
      send_block(1'(op), 32'hFFFFFFFF, 32'hFFFFFFFF);
      send_block(1'(op), 32'h0, 32'hFFFFFFFF);
      send_block(1'(op), 32'hFFFFFFFF, 32'h0);
      send_block(1'(op), 32'h80000000, 32'h00000001);
      send_block(1'(op), 32'h55555555, 32'hAAAAAAAA);
    end
    ct = sb.cipher(1'b0, 32'h12345678, 32'h9ABCDEF0);
    send_block(1'b1, ct[63:32], ct[31:0]);
    drain();
    write_keys(4'hF, '0, '0, '0, '0);
    send_block(1'b0, 32'h0, 32'h0);
    send_block(1'b1, 32'h0, 32'h0);
    send_block(1'b0, 32'hFFFFFFFF, 32'h00000000);
    drain();
    write_keys(4'hF, '1, '1, '1, '1);
    send_block(1'b0, 32'h0, 32'h0);
    send_block(1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_block(1'b0, 32'hDEADBEEF, 32'h01234567);
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      case (ph % 6)
        0: write_keys(4'hF, $urandom, $urandom, $urandom, $urandom);
        1: write_keys(4'hF, '1, '0, '1, '0);
        2: write_keys(4'h1 << $urandom_range(0, 3), $urandom, $urandom, $urandom,
                      $urandom);
        3: write_keys(4'hF, 32'h12447469, 32'h87873739, 32'h908ACD69, 32'hFC892782);
        4: write_keys(4'hF, 32'h55555555, 32'hAAAAAAAA, 32'h80000000, 32'h00000001);
        default: write_keys(4'hF, pick_word(), pick_word(), pick_word(), pick_word());
      endcase
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      if (ph == 3) begin
        // Back-pressure: the receiver holds off while blocks keep coming.
        tx_quiet = 1'b1;
        hold_req = 1'b1;
      end
      run_phase(92);
      drain();
    end

    rx_quiet = 1'b0;
    repeat (80) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
